[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the sector and compare block.
// Needs nothing else; the files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SVPC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SVPC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/svpc_pkg.sv]
// Package of the space-vector sector and compare block: widths, constants, types.
// Used by the interfaces and by every module of the block but svpc_div; depends on nothing.
`default_nettype none

package svpc_pkg;

  // Fixed-point scale of the sqrt(3) constant.
  localparam int SQRT3_FRAC_BITS = 16;
  localparam longint unsigned SQRT3_Q32 = 64'd7439101573;
  localparam int SQ_W = SQRT3_FRAC_BITS + 1;
  localparam logic [SQ_W-1:0] SQRT3_Q =
    SQ_W'((SQRT3_Q32 + (64'd1 << (31 - SQRT3_FRAC_BITS))) >> (32 - SQRT3_FRAC_BITS));

  // Field widths.
  localparam int VOLT_W = 16;
  localparam int BUS_W  = 16;
  localparam int PER_W  = 16;
  localparam int TIME_W = 16;

  // Internal widths: products, numerators, denominator, dividend.
  localparam int PROD_W = VOLT_W + SQ_W + 1;
  localparam int NUM_W  = SQRT3_FRAC_BITS + 19;
  localparam int DEN_W  = BUS_W + SQRT3_FRAC_BITS + 1;
  localparam int LO_W   = 18;
  localparam int HI_W   = NUM_W - 1 - LO_W;
  localparam int DVD_W  = PER_W + NUM_W - 1;

  localparam logic [PER_W-1:0] DEFAULT_PERIOD = 16'd4250;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    SECT_1 = 3'd1,
    SECT_2 = 3'd2,
    SECT_3 = 3'd3,
    SECT_4 = 3'd4,
    SECT_5 = 3'd5,
    SECT_6 = 3'd6
  } sector_t;

  typedef enum logic {
    STAT_OK      = 1'b0,
    STAT_OVERMOD = 1'b1
  } status_t;

  // A classified vector, as it waits between front and back.
  typedef struct packed {
    sector_t                  sector;
    logic signed [NUM_W-1:0]  n1;
    logic signed [NUM_W-1:0]  n2;
    logic [BUS_W-1:0]         bus;
    logic                     err;
  } item_t;

  // Head of the queue as the back end sees it.
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

endpackage

`default_nettype wire

[rtl/svpc_if.sv]
// Valid/ready channel interfaces for input vectors and result words.
// Depends on svpc_pkg for the field widths.
`default_nettype none

interface svpc_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [svpc_pkg::VOLT_W-1:0]    v_alpha;
  logic signed [svpc_pkg::VOLT_W-1:0]    v_beta;
  logic [svpc_pkg::BUS_W-1:0]            bus_voltage;

  modport source (output valid, v_alpha, v_beta, bus_voltage, input ready);
  modport sink (input valid, v_alpha, v_beta, bus_voltage, output ready);
endinterface

interface svpc_out_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    sector_number;
  logic [svpc_pkg::TIME_W-1:0]   zero_time;
  logic [svpc_pkg::TIME_W-1:0]   first_active_time;
  logic [svpc_pkg::TIME_W-1:0]   second_active_time;
  logic [svpc_pkg::TIME_W-1:0]   compare_a;
  logic [svpc_pkg::TIME_W-1:0]   compare_b;
  logic [svpc_pkg::TIME_W-1:0]   compare_c;
  logic                          status_code;

  modport source (output valid, sector_number, zero_time, first_active_time,
                  second_active_time, compare_a, compare_b, compare_c, status_code,
                  input ready);
  modport sink (input valid, sector_number, zero_time, first_active_time,
                second_active_time, compare_a, compare_b, compare_c, status_code,
                output ready);
endinterface

`default_nettype wire

[rtl/svpc_front.sv]
// Front end: takes input words, finds the sector and the time numerators.
// Depends on svpc_pkg and svpc_if.
`default_nettype none

module svpc_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  svpc_in_if.sink            in_ch,
  input  wire logic          push_ok,
  output svpc_pkg::item_t    push_item,
  output logic               push
);

  localparam int SF = svpc_pkg::SQRT3_FRAC_BITS;
  localparam int NW = svpc_pkg::NUM_W;

  logic                                  f_v_r, f_v_nxt;
  logic signed [svpc_pkg::VOLT_W-1:0]    va_r, vb_r;
  logic [svpc_pkg::BUS_W-1:0]            bus_r;
  logic signed [svpc_pkg::PROD_W-1:0]    s3va_r, b_r;
  logic                                  accept;

  logic signed [NW-1:0] a, a3, b, b2, vbs, s3va, n1, n2;
  svpc_pkg::sector_t    sector;

  // The stage frees up when its word moves into the queue.
  assign push         = f_v_r && push_ok;
  assign in_ch.ready  = !f_v_r || push_ok;
  assign accept       = in_ch.valid && in_ch.ready;

  always_comb begin
    f_v_nxt = f_v_r;
    if (accept) begin
      f_v_nxt = 1'b1;
    end else if (push) begin
      f_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else begin
      f_v_r <= f_v_nxt;
    end
  end

  // Products with sqrt(3) are registered before any further arithmetic.
  always_ff @(posedge clk) begin
    if (accept) begin
      va_r   <= in_ch.v_alpha;
      vb_r   <= in_ch.v_beta;
      bus_r  <= in_ch.bus_voltage;
      s3va_r <= svpc_pkg::PROD_W'(in_ch.v_alpha) *
                svpc_pkg::PROD_W'($signed({1'b0, svpc_pkg::SQRT3_Q}));
      b_r    <= svpc_pkg::PROD_W'(in_ch.v_beta) *
                svpc_pkg::PROD_W'($signed({1'b0, svpc_pkg::SQRT3_Q}));
    end
  end

  // Bring everything to the common scale.
  always_comb begin
    a    = NW'(va_r) <<< SF;
    vbs  = NW'(vb_r) <<< SF;
    s3va = NW'(s3va_r);
    b    = NW'(b_r);
    a3   = a + (a <<< 1);
    b2   = b <<< 1;
  end

  // Sector from sign tests and the sqrt(3) slopes.
  always_comb begin
    if (va_r < 0) begin
      if (vb_r > 0) begin
        sector = (vbs + s3va > 0) ? svpc_pkg::SECT_2 : svpc_pkg::SECT_3;
      end else begin
        sector = (vbs - s3va > 0) ? svpc_pkg::SECT_4 : svpc_pkg::SECT_5;
      end
    end else if (vb_r < 0) begin
      sector = (vbs + s3va < 0) ? svpc_pkg::SECT_5 : svpc_pkg::SECT_6;
    end else begin
      sector = (vbs - s3va < 0) ? svpc_pkg::SECT_1 : svpc_pkg::SECT_2;
    end
  end

  // Numerators of the two active times for the sector.
  always_comb begin
    unique case (sector)
      svpc_pkg::SECT_1: begin n1 = a3 - b;  n2 = b2;       end
      svpc_pkg::SECT_2: begin n1 = a3 + b;  n2 = b - a3;   end
      svpc_pkg::SECT_3: begin n1 = b2;      n2 = -a3 - b;  end
      svpc_pkg::SECT_4: begin n1 = b - a3;  n2 = -b2;      end
      svpc_pkg::SECT_5: begin n1 = -a3 - b; n2 = a3 - b;   end
      default:          begin n1 = -b2;     n2 = a3 + b;   end
    endcase
  end

  always_comb begin
    push_item.sector = sector;
    push_item.n1     = n1;
    push_item.n2     = n2;
    push_item.bus    = bus_r;
    push_item.err    = (bus_r == '0) || n1[NW-1] || n2[NW-1];
  end

endmodule

`default_nettype wire

[rtl/svpc_queue.sv]
// Short queue of classified vectors between front and back end.
// Depends on svpc_pkg.
`default_nettype none

module svpc_queue #(
  parameter int DEPTH = svpc_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  svpc_pkg::item_t        push_item,
  output logic                   push_ok,
  input  wire logic              pop,
  output svpc_pkg::q_head_t      head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  svpc_pkg::item_t     mem_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                do_pop;

  assign push_ok    = (cnt_r != CNT_W'(DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.item  = mem_r[rd_ptr_r];
  assign do_pop     = pop && head.valid;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

[rtl/svpc_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
// Stand-alone; the quotient must fit in Q_W bits.
`default_nettype none

module svpc_div #(
  parameter int DVD_W = 50,
  parameter int DEN_W = 33,
  parameter int Q_W   = 16
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [DVD_W-1:0]  dividend,
  input  wire logic [DEN_W-1:0]  divisor,
  output logic [Q_W-1:0]         quotient
);

  logic [DVD_W-1:0] rem_r [Q_W];
  logic [DEN_W-1:0] den_r [Q_W];
  logic [Q_W-1:0]   q_r   [Q_W];

  // Stage i settles quotient bit Q_W-1-i.
  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    logic [DVD_W-1:0] rem_in, shifted, rem_nxt;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   q_in, q_nxt;
    logic             ge;

    if (i == 0) begin : g_first
      assign rem_in = dividend;
      assign den_in = divisor;
      assign q_in   = '0;
    end else begin : g_rest
      assign rem_in = rem_r[i-1];
      assign den_in = den_r[i-1];
      assign q_in   = q_r[i-1];
    end

    always_comb begin
      shifted = DVD_W'(den_in) << (Q_W - 1 - i);
      ge      = (rem_in >= shifted);
      rem_nxt = ge ? rem_in - shifted : rem_in;
      q_nxt   = q_in | (Q_W'(ge) << (Q_W - 1 - i));
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= rem_nxt;
        den_r[i] <= den_in;
        q_r[i]   <= q_nxt;
      end
    end
  end

  assign quotient = q_r[Q_W-1];

endmodule

`default_nettype wire

[rtl/svpc_back.sv]
// Back end: scales numerators by the period, divides, forms times and compares.
// Depends on svpc_pkg, svpc_if and svpc_div.
`default_nettype none

module svpc_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [svpc_pkg::PER_W-1:0]  period,
  input  svpc_pkg::q_head_t                head,
  output logic                             pop,
  svpc_out_if.source                       out_ch
);

  localparam int SF  = svpc_pkg::SQRT3_FRAC_BITS;
  localparam int NW  = svpc_pkg::NUM_W;
  localparam int LW  = svpc_pkg::LO_W;
  localparam int HW  = svpc_pkg::HI_W;
  localparam int PW  = svpc_pkg::PER_W;
  localparam int DW  = svpc_pkg::DVD_W;
  localparam int EW  = svpc_pkg::DEN_W;
  localparam int TW  = svpc_pkg::TIME_W;

  logic en;

  // Stage 0: partial products and the overmodulation test.
  logic                   b0_v_r;
  logic [PW+LW-1:0]       p1lo_r, p2lo_r;
  logic [PW+HW-1:0]       p1hi_r, p2hi_r;
  logic [EW-1:0]          den0_r;
  svpc_pkg::sector_t      sect0_r;
  logic                   err0_r;
  logic signed [NW:0]     nsum, dext;
  logic                   err_nxt;

  // Stage 1: full dividends.
  logic                   b1_v_r;
  logic [DW-1:0]          dvd1_r, dvd2_r;
  logic [EW-1:0]          den1_r;
  svpc_pkg::sector_t      sect1_r;
  logic                   err1_r;

  // Side line that runs alongside the dividers.
  logic                   sv_r   [TW];
  svpc_pkg::sector_t      ssec_r [TW];
  logic                   serr_r [TW];

  logic [TW-1:0]          t1, t2, t0, first, ca, cb, cc;

  // Output register.
  logic                   out_v_r;
  svpc_pkg::sector_t      out_sect_r;
  logic [TW-1:0]          out_t0_r, out_t1_r, out_t2_r, out_ca_r, out_cb_r, out_cc_r;
  svpc_pkg::status_t      out_stat_r;

  // The whole line advances unless a finished word is held up.
  assign en  = !out_v_r || out_ch.ready;
  assign pop = en && head.valid;

  always_comb begin
    nsum    = {head.item.n1[NW-1], head.item.n1} + {head.item.n2[NW-1], head.item.n2};
    dext    = (NW+1)'({head.item.bus, {(SF+1){1'b0}}});
    err_nxt = head.item.err || ((period != '0) && (nsum > dext));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1lo_r  <= (PW+LW)'(period) * (PW+LW)'(head.item.n1[LW-1:0]);
      p2lo_r  <= (PW+LW)'(period) * (PW+LW)'(head.item.n2[LW-1:0]);
      p1hi_r  <= (PW+HW)'(period) * (PW+HW)'(head.item.n1[NW-2:LW]);
      p2hi_r  <= (PW+HW)'(period) * (PW+HW)'(head.item.n2[NW-2:LW]);
      den0_r  <= EW'({head.item.bus, {(SF+1){1'b0}}});
      sect0_r <= head.item.sector;
      err0_r  <= err_nxt;
      dvd1_r  <= (DW'(p1hi_r) << LW) + DW'(p1lo_r);
      dvd2_r  <= (DW'(p2hi_r) << LW) + DW'(p2lo_r);
      den1_r  <= den0_r;
      sect1_r <= sect0_r;
      err1_r  <= err0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_v_r <= 1'b0;
      b1_v_r <= 1'b0;
    end else if (en) begin
      b0_v_r <= head.valid;
      b1_v_r <= b0_v_r;
    end
  end

  svpc_div #(.DVD_W(DW), .DEN_W(EW), .Q_W(TW)) u_div1 (
    .clk(clk), .en(en), .dividend(dvd1_r), .divisor(den1_r), .quotient(t1)
  );

  svpc_div #(.DVD_W(DW), .DEN_W(EW), .Q_W(TW)) u_div2 (
    .clk(clk), .en(en), .dividend(dvd2_r), .divisor(den1_r), .quotient(t2)
  );

  // Sector and error travel with the dividers.
  for (genvar i = 0; i < TW; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[i] <= 1'b0;
      end else if (en) begin
        sv_r[i] <= (i == 0) ? b1_v_r : sv_r[(i == 0) ? 0 : i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ssec_r[i] <= (i == 0) ? sect1_r : ssec_r[(i == 0) ? 0 : i-1];
        serr_r[i] <= (i == 0) ? err1_r  : serr_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  // Zero time and the center-aligned compare order of each sector.
  always_comb begin
    t0    = period - t1 - t2;
    first = t0 >> 1;
    unique case (ssec_r[TW-1])
      svpc_pkg::SECT_1: begin ca = first; cb = ca + t1; cc = cb + t2; end
      svpc_pkg::SECT_2: begin cb = first; ca = cb + t2; cc = ca + t1; end
      svpc_pkg::SECT_3: begin cb = first; cc = cb + t1; ca = cc + t2; end
      svpc_pkg::SECT_4: begin cc = first; cb = cc + t2; ca = cb + t1; end
      svpc_pkg::SECT_5: begin cc = first; ca = cc + t1; cb = ca + t2; end
      default:          begin ca = first; cc = ca + t2; cb = cc + t1; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= sv_r[TW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_sect_r <= ssec_r[TW-1];
      if (serr_r[TW-1]) begin
        out_stat_r <= svpc_pkg::STAT_OVERMOD;
        out_t0_r   <= '0;
        out_t1_r   <= '0;
        out_t2_r   <= '0;
        out_ca_r   <= '0;
        out_cb_r   <= '0;
        out_cc_r   <= '0;
      end else begin
        out_stat_r <= svpc_pkg::STAT_OK;
        out_t0_r   <= t0;
        out_t1_r   <= t1;
        out_t2_r   <= t2;
        out_ca_r   <= ca;
        out_cb_r   <= cb;
        out_cc_r   <= cc;
      end
    end
  end

  assign out_ch.valid              = out_v_r;
  assign out_ch.sector_number      = out_sect_r;
  assign out_ch.zero_time          = out_t0_r;
  assign out_ch.first_active_time  = out_t1_r;
  assign out_ch.second_active_time = out_t2_r;
  assign out_ch.compare_a          = out_ca_r;
  assign out_ch.compare_b          = out_cb_r;
  assign out_ch.compare_c          = out_cc_r;
  assign out_ch.status_code        = out_stat_r;

endmodule

`default_nettype wire

[rtl/svpwm_sector_and_compare.sv]
// Center-aligned space-vector PWM: sector, active times and compare values.
// The input channel takes one word per vector: v_alpha, v_beta (signed Q8.8)
// and bus_voltage (unsigned Q8.8). The result channel gives one word per
// vector: sector 1..6, times T0/T1/T2, three phase compares and a status bit.
// cfg_we/cfg_wdata write the PWM period; write it only while no vector is
// in flight. It resets to 4250 counts.
// Throughput is one vector per cycle while out_ch.ready stays high. The result word
// reaches out_ch through the sqrt(3) product register (written at the accepting
// edge), the queue, two period-scaling stages, sixteen bit-per-stage divider
// stages and the output register, in that order.
// When a result word waits with ready low, the back end freezes; the two-entry
// queue and the front stage keep taking vectors until they fill, then
// in_ch.ready drops. Reset empties every stage and the queue.
// Status 1 marks zero bus voltage or overmodulation; the times and compares
// of that word are zero and the previous compares should be kept.
// Depends on svpc_pkg, svpc_if, svpc_front, svpc_queue, svpc_div, svpc_back.
`default_nettype none
`include "assert_macros.svh"

module svpwm_sector_and_compare #(
  parameter int QUEUE_DEPTH = svpc_pkg::QUEUE_DEPTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  svpc_in_if.sink                          in_ch,
  svpc_out_if.source                       out_ch,
  input  wire logic                        cfg_we,
  input  wire logic [svpc_pkg::PER_W-1:0]  cfg_wdata
);

  logic [svpc_pkg::PER_W-1:0] pwm_period_r;
  svpc_pkg::item_t            push_item;
  svpc_pkg::q_head_t          head;
  logic                       push, push_ok, pop;

  // Period register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_period_r <= svpc_pkg::DEFAULT_PERIOD;
    end else if (cfg_we) begin
      pwm_period_r <= cfg_wdata;
    end
  end

  svpc_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .push_ok(push_ok), .push_item(push_item), .push(push)
  );

  svpc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_item(push_item),
    .push_ok(push_ok), .pop(pop), .head(head)
  );

  svpc_back u_back (
    .clk(clk), .rst_n(rst_n), .period(pwm_period_r),
    .head(head), .pop(pop), .out_ch(out_ch)
  );

  // A good word splits the period exactly into T0, T1 and T2.
  `SVPC_ASSERT_IMP(a_time_sum, clk, rst_n, out_ch.valid && !out_ch.status_code, (svpc_pkg::TIME_W'(out_ch.zero_time + out_ch.first_active_time + out_ch.second_active_time) == pwm_period_r), "times do not add up to the period")

  // An error word carries no times or compares.
  `SVPC_ASSERT_IMP(a_err_zero, clk, rst_n, out_ch.valid && out_ch.status_code, (out_ch.zero_time == '0) && (out_ch.compare_a == '0) && (out_ch.compare_b == '0) && (out_ch.compare_c == '0), "error word with nonzero fields")

  // The queue is never pushed while full.
  `SVPC_ASSERT_IMP(a_no_overrun, clk, rst_n, push, push_ok, "queue overrun")

endmodule

`default_nettype wire
